[sv/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// Summed frame deframer package
// Shared types, constants and the class-to-route mapping.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0]  HdrByte  = 8'h55;
    localparam logic [4:0]  LenMin   = 5'd8;
    localparam logic [4:0]  LenMax   = 5'd16;
    localparam logic [13:0] ErrLimit = 14'd10000;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic {
        KIND_GOOD    = 1'b0,
        KIND_BAD_SUM = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   unit_class;
        logic [7:0]   unit_kind;
        logic [7:0]   unit_num;
        logic [7:0]   func_code;
        logic [3:0]   payload_len;
        logic [63:0]  payload;
        logic [3:0]   route;
        logic [13:0]  error_count;
    } result_t;

    // Classes 1 to 3 map straight through, classes 5 to 9 close the gap at 4.
    function automatic logic [3:0] route_of(input logic [7:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= 8'd1 && c <= 8'd3)
        begin
            r = c[3:0];
        end
        else if (c >= 8'd5 && c <= 8'd9)
        begin
            r = c[3:0] - 4'd1;
        end
        return r;
    endfunction

endpackage

[sv/summed_frame_deframer.sv]
// ----------------------------------------------------------------------------
// Summed frame deframer
// Usage:
//   The slave stream carries one received byte per word. The parser hunts
//   for header 0x55, takes a total length of 8 to 16, collects class, type,
//   number, function and payload, and checks the last byte against the
//   8-bit sum of all earlier frame bytes.
//   The master stream carries one word per finished frame: tuser is the
//   kind (good frame or checksum error), tdata holds the decoded fields.
//   Latency: the result word is valid in the cycle after the last frame
//   byte is taken. Throughput: one byte per cycle, set by the single
//   per-byte compare-and-add step ahead of the output register.
//   Reset clears the parser to hunting, the error count to zero and drops
//   any pending result word.
//   While a result word waits and m_tready is low, s_tready is low; when the
//   output register is empty or being drained, a byte is taken every cycle.
// ----------------------------------------------------------------------------
module summed_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // rx_byte[7:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    // unit_class[7:0], unit_kind[15:8], unit_num[23:16], func_code[31:24],
    // payload_len[35:32], payload[99:36], route[103:100], error_count[117:104],
    // zero padding[119:118]
    output logic [119:0]  m_tdata,
    output logic [0:0]    m_tuser    // kind[0]
);

    logic             accept;
    logic             res_valid;
    sfd_pkg::result_t res;
    sfd_pkg::result_t result_reg;
    logic             valid_reg;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sfd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.kind;
    assign m_tdata  = {2'b00, result_reg.error_count, result_reg.route, result_reg.payload,
                       result_reg.payload_len, result_reg.func_code, result_reg.unit_num,
                       result_reg.unit_kind, result_reg.unit_class};

endmodule

[sv/sfd_parse.sv]
// ----------------------------------------------------------------------------
// Summed frame deframer parser
// Frame state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module sfd_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_en,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output sfd_pkg::result_t    res
);

    sfd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  len_reg, len_next;
    logic [4:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] id_reg, id_next;
    logic [63:0] pay_reg, pay_next;
    logic [13:0] errs_reg, errs_next;

    logic [13:0] errs_inc;
    logic [1:0]  id_slot;
    logic [2:0]  pay_slot;
    logic        frame_end;
    logic        pay_byte;

    assign errs_inc  = errs_reg + 14'd1;
    assign id_slot   = 2'(idx_reg - 5'd2);
    assign pay_slot  = 3'(idx_reg - 5'd6);
    assign frame_end = ({1'b0, idx_reg} + 6'd1) >= {1'b0, len_reg};
    assign pay_byte  = (idx_reg >= 5'd6) && (({1'b0, idx_reg} + 6'd2) < {1'b0, len_reg});

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        pay_next   = pay_reg;
        errs_next  = errs_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (phase_reg)
            sfd_pkg::PH_LEN:
            begin
                if (rx_byte >= 8'(sfd_pkg::LenMin) && rx_byte <= 8'(sfd_pkg::LenMax))
                begin
                    len_next   = rx_byte[4:0];
                    sum_next   = sum_reg + rx_byte;
                    idx_next   = 5'd2;
                    phase_next = sfd_pkg::PH_BODY;
                end
                else if (rx_byte == sfd_pkg::HdrByte)
                begin
                    phase_next = sfd_pkg::PH_LEN;
                    sum_next   = sfd_pkg::HdrByte;
                    id_next    = '0;
                    pay_next   = '0;
                    len_next   = '0;
                    idx_next   = 5'd1;
                end
                else
                begin
                    phase_next = sfd_pkg::PH_HUNT;
                end
            end
            sfd_pkg::PH_BODY:
            begin
                if (frame_end)
                begin
                    phase_next = sfd_pkg::PH_HUNT;
                    idx_next   = '0;
                    sum_next   = '0;
                    res_valid  = 1'b1;
                    if (rx_byte == sum_reg)
                    begin
                        res.kind        = sfd_pkg::KIND_GOOD;
                        res.unit_class  = id_reg[7:0];
                        res.unit_kind   = id_reg[15:8];
                        res.unit_num    = id_reg[23:16];
                        res.func_code   = id_reg[31:24];
                        res.payload_len = 4'(len_reg - sfd_pkg::LenMin);
                        res.payload     = pay_reg;
                        res.route       = sfd_pkg::route_of(id_reg[7:0]);
                        res.error_count = errs_reg;
                    end
                    else
                    begin
                        res.kind        = sfd_pkg::KIND_BAD_SUM;
                        res.error_count = errs_inc;
                        // The count wraps to zero once the value past the limit is reported.
                        errs_next       = (errs_inc > sfd_pkg::ErrLimit) ? 14'd0 : errs_inc;
                    end
                end
                else
                begin
                    if (idx_reg >= 5'd2 && idx_reg <= 5'd5)
                    begin
                        id_next[{id_slot, 3'b000} +: 8] = rx_byte;
                    end
                    else if (pay_byte)
                    begin
                        pay_next[{pay_slot, 3'b000} +: 8] = rx_byte;
                    end
                    sum_next = sum_reg + rx_byte;
                    idx_next = idx_reg + 5'd1;
                end
            end
            default:
            begin
                phase_next = sfd_pkg::PH_HUNT;
                if (rx_byte == sfd_pkg::HdrByte)
                begin
                    phase_next = sfd_pkg::PH_LEN;
                    sum_next   = sfd_pkg::HdrByte;
                    id_next    = '0;
                    pay_next   = '0;
                    len_next   = '0;
                    idx_next   = 5'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfd_pkg::PH_HUNT;
            len_reg   <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            id_reg    <= '0;
            pay_reg   <= '0;
            errs_reg  <= '0;
        end
        else if (byte_en)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            pay_reg   <= pay_next;
            errs_reg  <= errs_next;
        end
    end

endmodule

[sv/sfd_checker.sv]
// ----------------------------------------------------------------------------
// Summed frame deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [119:0]  m_tdata,
    input  logic [0:0]    m_tuser
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // With no result waiting the block is always ready to take a byte.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A stalled output register holds off an offered byte.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && m_tvalid && !m_tready |-> !s_tready)
        else $error("byte taken while a result word was stalled");

    // An error word reports only the count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[103:0] == 104'd0 && m_tdata[117:104] != 14'd0)
        else $error("checksum error word carries frame fields");

    // Good frames carry legal lengths and routes.
    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[35:32] <= 4'd8 && m_tdata[103:100] <= 4'd8)
        else $error("good frame with illegal length or route");

endmodule

bind summed_frame_deframer sfd_checker u_sfd_checker (.*);
